[src/compacting_directory_table_unit_assert.svh]
// Assertion macros used by the directory table top level.
`ifndef COMPACTING_DIRECTORY_TABLE_UNIT_ASSERT_SVH
`define COMPACTING_DIRECTORY_TABLE_UNIT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define CDT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition is followed by another on the next edge.
`define CDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/cdt_pkg.sv]
// Types, constants and helper functions for the directory table.
`timescale 1ns / 1ps
package cdt_pkg;

  localparam int CAPACITY   = 128;
  localparam int NAME_BYTES = 8;
  localparam int IDX_W      = 7;
  localparam int CNT_W      = 8;
  localparam int NAME_W     = 64;
  localparam int SIZE_W     = 31;

  typedef enum logic [1:0] {
    KIND_CREATE = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_READ   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EXISTS    = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_RANGE     = 3'd5
  } status_e;

  typedef struct packed {
    kind_e             kind;
    logic [NAME_W-1:0] name_key;
    logic [SIZE_W-1:0] entry_size_in;
    logic [IDX_W-1:0]  read_index;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic [IDX_W-1:0]  entry_position;
    logic [SIZE_W-1:0] entry_size_out;
    logic [NAME_W-1:0] entry_name_out;
    logic [CNT_W-1:0]  entry_count;
  } out_item_t;

  // Control broadcast to every cell of the table.
  typedef struct packed {
    logic [NAME_W-1:0] key;
    logic              is_read;
    logic [IDX_W-1:0]  ridx;
    logic [CNT_W-1:0]  count;
    logic              wr_en;
    logic [SIZE_W-1:0] wr_size;
    logic              shift_en;
    logic [IDX_W-1:0]  shift_pos;
  } cell_ctrl_t;

  // Selected entry gathered from the cells.
  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  pos;
    logic [SIZE_W-1:0] size;
    logic [NAME_W-1:0] name;
  } hit_t;

  // Keep the low NAME_BYTES bytes and clear everything from the first NUL up.
  function automatic logic [NAME_W-1:0] norm_key(input logic [NAME_W-1:0] key);
    logic [NAME_W-1:0] res;
    logic              stop;
    res  = '0;
    stop = 1'b0;
    for (int b = 0; b < NAME_BYTES; b++) begin
      if (key[8*b +: 8] == 8'h00) begin
        stop = 1'b1;
      end
      if (!stop) begin
        res[8*b +: 8] = key[8*b +: 8];
      end
    end
    return res;
  endfunction

endpackage

[src/compacting_directory_table_unit.sv]
// Top level of the compacting directory table.
`timescale 1ns / 1ps
`include "compacting_directory_table_unit_assert.svh"
// A directory of up to CAPACITY named entries (a normalised name key and a
// size) kept in insertion order in a row of cells. Each item goes through
// these steps in order: it is taken in and its key normalised; every cell
// compares its entry against the key (or its own index against read_index);
// the first half of the OR tree that gathers the single matching cell is
// registered; and the result is formed and the row updated. The result is
// loaded as the row leaves the finish state. The row works on one item at
// a time, so the next item is taken once the current one has finished; a
// result waiting at the output does not hold the input back, but a second
// result stalls in the last stage until the first is taken. Create writes
// the cell at the current count; delete makes every cell at or above the
// removed index take its upper neighbour's entry in the same cycle. Cells
// at or above the count hold stale data and are masked out of every compare.
// No clearing pass follows reset.
module compacting_directory_table_unit import cdt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_RED  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  kind_e               kind_q;
  logic [NAME_W-1:0]   key_q;
  logic [SIZE_W-1:0]   size_in_q;
  logic [IDX_W-1:0]    ridx_q;
  logic [CAPACITY-1:0] sel_q;
  logic                out_valid_q;
  out_item_t           out_q, out_d;

  logic [CAPACITY-1:0]             match;
  logic [CAPACITY-1:0][NAME_W-1:0] names;
  logic [CAPACITY-1:0][SIZE_W-1:0] sizes;
  cell_ctrl_t ctrl;
  hit_t       hit;
  logic       in_take;
  logic       fin_go;
  logic       do_write;
  logic       do_shift;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_take     = in_valid_i && in_ready_o;
  // Finish only once the output register is free or being emptied.
  assign fin_go      = (state_q == S_FIN) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Row of cells; the top cell feeds itself since the count drops anyway.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [NAME_W-1:0] nxt_name;
    logic [SIZE_W-1:0] nxt_size;
    if (i + 1 < CAPACITY) begin : g_mid
      assign nxt_name = names[i + 1];
      assign nxt_size = sizes[i + 1];
    end else begin : g_top
      assign nxt_name = names[i];
      assign nxt_size = sizes[i];
    end
    cdt_cell u_cell (
      .clk_i       (clk_i),
      .cell_idx_i  (CNT_W'(i)),
      .ctrl_i      (ctrl),
      .next_name_i (nxt_name),
      .next_size_i (nxt_size),
      .name_o      (names[i]),
      .size_o      (sizes[i]),
      .match_o     (match[i])
    );
  end

  cdt_select_tree u_tree (
    .clk_i   (clk_i),
    .sel_i   (sel_q),
    .names_i (names),
    .sizes_i (sizes),
    .hit_o   (hit)
  );

  // Work out the result and the row update from the gathered hit.
  always_comb begin
    out_d    = '0;
    count_d  = count_q;
    do_write = 1'b0;
    do_shift = 1'b0;
    out_d.status = ST_OK;
    if (kind_q == KIND_CREATE) begin
      if (count_q >= CNT_W'(CAPACITY)) begin
        out_d.status = ST_FULL;
      end else if (hit.found) begin
        out_d.status         = ST_EXISTS;
        out_d.entry_position = hit.pos;
      end else begin
        out_d.entry_position = count_q[IDX_W-1:0];
        do_write             = 1'b1;
        count_d              = count_q + CNT_W'(1);
      end
    end else if (count_q == '0) begin
      out_d.status = ST_EMPTY;
    end else if (kind_q == KIND_READ) begin
      if (CNT_W'(ridx_q) >= count_q) begin
        out_d.status = ST_RANGE;
      end else begin
        out_d.entry_position = ridx_q;
        out_d.entry_size_out = hit.size;
        out_d.entry_name_out = hit.name;
      end
    end else if (!hit.found) begin
      out_d.status = ST_NOT_FOUND;
    end else begin
      out_d.entry_position = hit.pos;
      out_d.entry_size_out = hit.size;
      out_d.entry_name_out = hit.name;
      if (kind_q == KIND_DELETE) begin
        do_shift = 1'b1;
        count_d  = count_q - CNT_W'(1);
      end
    end
    out_d.entry_count = count_d;
  end

  always_comb begin
    ctrl           = '0;
    ctrl.key       = key_q;
    ctrl.is_read   = (kind_q == KIND_READ);
    ctrl.ridx      = ridx_q;
    ctrl.count     = count_q;
    ctrl.wr_en     = fin_go && do_write;
    ctrl.wr_size   = size_in_q;
    ctrl.shift_en  = fin_go && do_shift;
    ctrl.shift_pos = hit.pos;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_take) state_d = S_CMP;
      S_CMP:   state_d = S_RED;
      S_RED:   state_d = S_FIN;
      S_FIN:   if (fin_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      sel_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CMP) begin
        sel_q <= match;
      end
      if (fin_go) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the item fields for the whole operation; load the result on finish.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      kind_q    <= in_item_i.kind;
      key_q     <= norm_key(in_item_i.name_key);
      size_in_q <= in_item_i.entry_size_in;
      ridx_q    <= in_item_i.read_index;
    end
    if (fin_go) begin
      out_q <= out_d;
    end
  end

  `CDT_ASSERT(a_sel_onehot, (state_q != S_RED) || $onehot0(sel_q),
              "more than one cell selected")
  `CDT_ASSERT(a_count_bound, count_q <= CNT_W'(CAPACITY), "entry count above capacity")
  `CDT_ASSERT(a_count_only_fin,
              (count_q == $past(count_q)) || ($past(state_q) == S_FIN),
              "count moved outside finish")
  `CDT_ASSERT_NEXT(a_fin_loads_out, fin_go, out_valid_q && (state_q == S_IDLE),
                   "finish did not load result")

endmodule

[src/cdt_cell.sv]
// One table slot: holds an entry, matches it and shifts it down on delete.
`timescale 1ns / 1ps
module cdt_cell import cdt_pkg::*; (
  input  logic              clk_i,
  input  logic [CNT_W-1:0]  cell_idx_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [NAME_W-1:0] next_name_i,
  input  logic [SIZE_W-1:0] next_size_i,
  output logic [NAME_W-1:0] name_o,
  output logic [SIZE_W-1:0] size_o,
  output logic              match_o
);

  logic [NAME_W-1:0] name_q;
  logic [SIZE_W-1:0] size_q;
  logic              live;

  assign live    = cell_idx_i < ctrl_i.count;
  assign match_o = live & (ctrl_i.is_read ? (cell_idx_i == CNT_W'(ctrl_i.ridx))
                                          : (name_q == ctrl_i.key));
  assign name_o  = name_q;
  assign size_o  = size_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en && (cell_idx_i == ctrl_i.count)) begin
      name_q <= ctrl_i.key;
      size_q <= ctrl_i.wr_size;
    end else if (ctrl_i.shift_en && (cell_idx_i >= CNT_W'(ctrl_i.shift_pos))) begin
      name_q <= next_name_i;
      size_q <= next_size_i;
    end
  end

endmodule

[src/cdt_select_tree.sv]
// Two-stage OR tree that gathers the one selected cell's entry and index.
`timescale 1ns / 1ps
module cdt_select_tree import cdt_pkg::*; (
  input  logic                           clk_i,
  input  logic [CAPACITY-1:0]            sel_i,
  input  logic [CAPACITY-1:0][NAME_W-1:0] names_i,
  input  logic [CAPACITY-1:0][SIZE_W-1:0] sizes_i,
  output hit_t                           hit_o
);

  localparam int GROUP  = 16;
  localparam int NGROUP = (CAPACITY + GROUP - 1) / GROUP;

  hit_t grp_d [NGROUP];
  hit_t grp_q [NGROUP];

  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < GROUP; j++) begin
        if ((g * GROUP + j < CAPACITY) && sel_i[g * GROUP + j]) begin
          grp_d[g].found = 1'b1;
          grp_d[g].pos   = grp_d[g].pos  | IDX_W'(g * GROUP + j);
          grp_d[g].size  = grp_d[g].size | sizes_i[g * GROUP + j];
          grp_d[g].name  = grp_d[g].name | names_i[g * GROUP + j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < NGROUP; g++) begin
      grp_q[g] <= grp_d[g];
    end
  end

  always_comb begin
    hit_o = '0;
    for (int g = 0; g < NGROUP; g++) begin
      hit_o = hit_o | grp_q[g];
    end
  end

endmodule

[bench/testbench.sv]
// Self-checking testbench for the compacting directory table unit.
`timescale 1ns / 1ps
// Drive create, delete, search and read items through the valid/ready input
// channel and collect results on the output channel. A scoreboard keeps its
// own copy of the table (names, sizes and the entry count) and works out the
// expected result for every accepted item. Each collected result is compared
// field by field with the oldest expectation.
//
// Stimulus runs in two parts:
//  - a short directed part covering the empty table, names cut short by an
//    embedded NUL, the empty name, duplicates, missing names, reads in and
//    out of range, and deletes at the front, middle and back of the table;
//  - random phases that fill the table towards full, drain it towards empty
//    or mix all operations, with keys drawn mostly from a pool of names so
//    that duplicates, hits and deletes of live entries are common.
// Both channels idle and stall at random. One mixed phase runs with no
// sender gaps. A watchdog ends the run if nothing moves for too long.
module testbench import cdt_pkg::*;;

  localparam int POOL_N      = 200;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 16;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_e;

  // Scoreboard: a private copy of the table plus the queue of results that
  // are owed by the block.
  class dir_table_tracker;
    logic [NAME_W-1:0] names [CAPACITY];
    logic [SIZE_W-1:0] sizes [CAPACITY];
    int unsigned       used;
    out_item_t         owed_results [$];
    int unsigned       mismatches;
    int unsigned       kind_seen [4];
    int unsigned       status_seen [8];

    function new();
      used       = 0;
      mismatches = 0;
      foreach (names[i]) begin
        names[i] = '0;
        sizes[i] = '0;
      end
      foreach (kind_seen[i]) kind_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // Cut a key at its first NUL byte and at NAME_BYTES bytes.
    static function logic [NAME_W-1:0] trim_name(logic [NAME_W-1:0] raw);
      int                len;
      logic [NAME_W-1:0] keep;
      len = 0;
      while (len < NAME_BYTES && raw[8*len +: 8] != 8'h00) len++;
      keep = (len >= 8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
      return raw & keep;
    endfunction

    function int locate(logic [NAME_W-1:0] key);
      for (int i = 0; i < used; i++) begin
        if (names[i] == key) return i;
      end
      return -1;
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction

    // Apply one accepted item to the private table and queue its result.
    function void note_request(in_item_t req);
      out_item_t         want;
      logic [NAME_W-1:0] key;
      int                hit;
      key  = trim_name(req.name_key);
      want = '0;
      want.status = ST_OK;
      kind_seen[req.kind]++;
      if (req.kind == KIND_CREATE) begin
        // A full table is reported ahead of a duplicate name.
        if (used >= CAPACITY) begin
          want.status = ST_FULL;
        end else begin
          hit = locate(key);
          if (hit >= 0) begin
            want.status         = ST_EXISTS;
            want.entry_position = IDX_W'(hit);
          end else begin
            names[used]         = key;
            sizes[used]         = req.entry_size_in;
            want.entry_position = IDX_W'(used);
            used++;
          end
        end
      end else if (used == 0) begin
        want.status = ST_EMPTY;
      end else if (req.kind == KIND_READ) begin
        if (req.read_index >= used) begin
          want.status = ST_RANGE;
        end else begin
          want.entry_position = req.read_index;
          want.entry_size_out = sizes[req.read_index];
          want.entry_name_out = names[req.read_index];
        end
      end else begin
        hit = locate(key);
        if (hit < 0) begin
          want.status = ST_NOT_FOUND;
        end else begin
          want.entry_position = IDX_W'(hit);
          want.entry_size_out = sizes[hit];
          want.entry_name_out = names[hit];
          if (req.kind == KIND_DELETE) begin
            // Close the gap: every later entry moves down one place.
            for (int i = hit; i + 1 < used; i++) begin
              names[i] = names[i+1];
              sizes[i] = sizes[i+1];
            end
            used--;
          end
        end
      end
      want.entry_count = CNT_W'(used);
      status_seen[want.status]++;
      owed_results.push_back(want);
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] seen);
      if (seen !== want) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, seen);
        mismatches++;
      end
    endfunction

    function void check_reply(out_item_t got);
      out_item_t want;
      if (owed_results.size() == 0) begin
        $error("result with nothing owed: status %0d, position %0d, count %0d",
               got.status, got.entry_position, got.entry_count);
        mismatches++;
        return;
      end
      want = owed_results.pop_front();
      compare_field("status", 64'(want.status), 64'(got.status));
      compare_field("entry_position", 64'(want.entry_position), 64'(got.entry_position));
      compare_field("entry_size_out", 64'(want.entry_size_out), 64'(got.entry_size_out));
      compare_field("entry_name_out", want.entry_name_out, got.entry_name_out);
      compare_field("entry_count", 64'(want.entry_count), 64'(got.entry_count));
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  dir_table_tracker  tracker;
  logic [NAME_W-1:0] name_pool [POOL_N];
  int unsigned       idle_cycles = 0;

  compacting_directory_table_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Sample both handshakes at the rising edge; inputs only move at the
  // falling edge, so the sampled values are settled.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) tracker.note_request(in_item_i);
      if (out_valid_o && out_ready_i) tracker.check_reply(out_item_o);
    end
  end

  // Watchdog: give up once nothing has been accepted for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Length of the idle stretch before the next item: mostly none or short,
  // now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Number of bytes before the first NUL of a trimmed name.
  function automatic int key_bytes(logic [NAME_W-1:0] key);
    int len;
    len = 0;
    while (len < 8 && key[8*len +: 8] != 8'h00) len++;
    return len;
  endfunction

  // Fill the bytes above a short name's terminator with junk; the block has
  // to ignore all of it.
  function automatic logic [NAME_W-1:0] add_junk(logic [NAME_W-1:0] key);
    int                len;
    logic [NAME_W-1:0] junk;
    len = key_bytes(key);
    if (len >= 8) return key;
    junk = {$urandom, $urandom};
    return key | (junk << (8 * (len + 1)));
  endfunction

  function automatic logic [NAME_W-1:0] live_name();
    return tracker.names[$urandom_range(0, tracker.used - 1)];
  endfunction

  // A pool name not in the table, if one turns up within a few tries.
  function automatic logic [NAME_W-1:0] fresh_name();
    logic [NAME_W-1:0] key;
    key = name_pool[$urandom_range(0, POOL_N - 1)];
    for (int t = 0; t < 8 && tracker.locate(key) >= 0; t++) begin
      key = name_pool[$urandom_range(0, POOL_N - 1)];
    end
    return key;
  endfunction

  function automatic logic [NAME_W-1:0] choose_key(kind_e kind);
    int r;
    r = $urandom_range(0, 99);
    if (kind == KIND_READ) return {$urandom, $urandom};
    if (kind == KIND_CREATE) begin
      if (r < 50) return fresh_name();
      if (r < 70 && tracker.used > 0) return add_junk(live_name());
      if (r < 85) return add_junk(name_pool[$urandom_range(0, POOL_N - 1)]);
      return {$urandom, $urandom};
    end
    if (r < 50 && tracker.used > 0) return live_name();
    if (r < 75 && tracker.used > 0) return add_junk(live_name());
    if (r < 92) return name_pool[$urandom_range(0, POOL_N - 1)];
    return {$urandom, $urandom};
  endfunction

  // Random item whose mix of operations depends on the phase.
  function automatic in_item_t make_item(phase_e phase);
    in_item_t it;
    int       r;
    int       w_create;
    int       w_delete;
    int       w_search;
    case (phase)
      PH_FILL: begin
        w_create = 80; w_delete = 5;  w_search = 8;
      end
      PH_DRAIN: begin
        w_create = 10; w_delete = 70; w_search = 10;
      end
      default: begin
        w_create = 35; w_delete = 25; w_search = 20;
      end
    endcase
    r = $urandom_range(0, 99);
    if (r < w_create) it.kind = KIND_CREATE;
    else if (r < w_create + w_delete) it.kind = KIND_DELETE;
    else if (r < w_create + w_delete + w_search) it.kind = KIND_SEARCH;
    else it.kind = KIND_READ;
    it.name_key = choose_key(it.kind);
    r = $urandom_range(0, 99);
    if (r < 5) it.entry_size_in = '0;
    else if (r < 10) it.entry_size_in = '1;
    else it.entry_size_in = SIZE_W'($urandom);
    if ($urandom_range(0, 99) < 70) begin
      it.read_index = IDX_W'($urandom_range(0, (tracker.used > 127) ? 127 : tracker.used));
    end else begin
      it.read_index = IDX_W'($urandom_range(0, 127));
    end
    return it;
  endfunction

  // Present one item and hold it until the block takes it. Called and left
  // at a falling edge, so valid stays high between back-to-back items.
  task automatic drive_item(in_item_t it, bit gapless);
    int gap;
    gap = gapless ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_item_i  = it;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic hold_ready(bit level, int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      out_ready_i = level;
    end
  endtask

  // Result side: bursts of ready with stalls of random length, and now and
  // then a long stretch with no stall at all.
  initial begin
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 99) < 10) begin
        hold_ready(1'b1, $urandom_range(150, 300));
      end else begin
        hold_ready(1'b1, $urandom_range(1, 12));
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: hold_ready(1'b0, $urandom_range(1, 2));
          6, 7, 8:          hold_ready(1'b0, $urandom_range(3, 8));
          default:          hold_ready(1'b0, $urandom_range(20, 60));
        endcase
      end
    end
  end

  initial begin
    in_item_t          script [$];
    phase_e            plan_phase [5];
    int                plan_items [5];
    logic [NAME_W-1:0] key;
    int                len;
    bit                clash;

    // Drive every input to a known value from time zero.
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_ready_i = 1'b0;
    tracker     = new();

    // Build a pool of distinct non-empty names of one to eight bytes.
    for (int p = 0; p < POOL_N; p++) begin
      do begin
        len = $urandom_range(1, 8);
        key = '0;
        for (int b = 0; b < len; b++) key[8*b +: 8] = 8'($urandom_range(1, 255));
        clash = 1'b0;
        for (int q = 0; q < p; q++) if (name_pool[q] == key) clash = 1'b1;
      end while (clash);
      name_pool[p] = key;
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. Every operation on an empty table first.
    script.push_back('{KIND_SEARCH, 64'h6261, 31'd0, 7'd0});
    script.push_back('{KIND_DELETE, 64'h6261, 31'd0, 7'd0});
    script.push_back('{KIND_READ,   64'h0,    31'd0, 7'd0});
    // Widest name and size, then the empty name with size zero.
    script.push_back('{KIND_CREATE, '1,  '1,    7'd0});
    script.push_back('{KIND_CREATE, '0,  31'd0, 7'd0});
    // Name cut short by a NUL, with junk above it.
    script.push_back('{KIND_CREATE, 64'hFFFF_FF00_0000_6261, 31'd5, 7'd0});
    // Duplicates, one written plainly and one with all bytes set.
    script.push_back('{KIND_CREATE, 64'h0000_0000_0000_6261, 31'd9, 7'd0});
    script.push_back('{KIND_CREATE, '1, 31'd3, 7'd0});
    // Hit through a junk-padded key, then a miss.
    script.push_back('{KIND_SEARCH, 64'h1234_5600_0000_6261, 31'd0, 7'd0});
    script.push_back('{KIND_SEARCH, 64'h7A7A, 31'd0, 7'd0});
    // Reads in range, at the count, and at the top index.
    script.push_back('{KIND_READ, 64'h0, 31'd0, 7'd0});
    script.push_back('{KIND_READ, 64'h0, 31'd0, 7'd2});
    script.push_back('{KIND_READ, 64'h0, 31'd0, 7'd3});
    script.push_back('{KIND_READ, '1,    '1,    7'd127});
    script.push_back('{KIND_CREATE, 64'h63, 31'd1, 7'd0});
    script.push_back('{KIND_CREATE, 64'h64, 31'h4000_0000, 7'd0});
    // Delete in the middle, check the shift, then the front and the back.
    script.push_back('{KIND_DELETE, 64'h6261, 31'd0, 7'd0});
    script.push_back('{KIND_READ,   64'h0, 31'd0, 7'd2});
    script.push_back('{KIND_DELETE, '1, 31'd0, 7'd0});
    script.push_back('{KIND_DELETE, 64'h64, 31'd0, 7'd0});
    script.push_back('{KIND_DELETE, 64'h6261, 31'd0, 7'd0});
    // A key with a NUL in its first byte means the empty name.
    script.push_back('{KIND_SEARCH, 64'hFFFF_FFFF_FFFF_FF00, 31'd0, 7'd0});
    script.push_back('{KIND_DELETE, 64'h63, 31'd0, 7'd0});
    script.push_back('{KIND_DELETE, 64'h0, 31'd0, 7'd0});
    script.push_back('{KIND_READ,   64'h0, 31'd0, 7'd0});
    foreach (script[i]) drive_item(script[i], 1'b0);

    // Random part: fill towards full, mix with no sender gaps, drain towards
    // empty, and round again.
    plan_phase = '{PH_FILL, PH_MIXED, PH_DRAIN, PH_FILL, PH_DRAIN};
    plan_items = '{300, 250, 300, 300, 275};
    for (int ph = 0; ph < 5; ph++) begin
      for (int n = 0; n < plan_items[ph]; n++) begin
        drive_item(make_item(plan_phase[ph]), plan_phase[ph] == PH_MIXED);
      end
    end
    in_valid_i = 1'b0;

    // Drain the owed results, then watch a little longer for strays.
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Items: %0d create, %0d delete, %0d search, %0d read.",
             tracker.kind_seen[KIND_CREATE], tracker.kind_seen[KIND_DELETE],
             tracker.kind_seen[KIND_SEARCH], tracker.kind_seen[KIND_READ]);
    $display("Outcomes: %0d ok, %0d full, %0d exists, %0d missing, %0d empty, %0d out of range.",
             tracker.status_seen[ST_OK], tracker.status_seen[ST_FULL],
             tracker.status_seen[ST_EXISTS], tracker.status_seen[ST_NOT_FOUND],
             tracker.status_seen[ST_EMPTY], tracker.status_seen[ST_RANGE]);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
